FILE: rtl/core/luc_pkg.sv
// Shared types, constants and helpers for the latch unlock pulse controller.
// No dependencies; every other file refers to it by scoped names.
package luc_pkg;

  // Counter width for elapsed and since-last timers (range 8 to 32)
  localparam int TIME_WIDTH = 16;
  // Fixed width of the millisecond fields on the ports
  localparam int FIELD_W = 16;
  // Wide enough to compare timer values against field values
  localparam int WIDE_W = (TIME_WIDTH > FIELD_W) ? TIME_WIDTH : FIELD_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UNLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [FIELD_W-1:0] MAX_UNLOCK_RESET = 16'd5000;
  localparam logic [FIELD_W-1:0] MIN_INTERVAL_RESET = 16'd2000;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_STARTED = 3'd0;
  localparam logic [2:0] ST_TOO_SOON = 3'd1;
  localparam logic [2:0] ST_ALREADY_OPEN = 3'd2;
  localparam logic [2:0] ST_BUSY = 3'd3;
  localparam logic [2:0] ST_NOTHING = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;
  localparam logic [2:0] ST_TIMED_OUT = 3'd6;

  typedef struct packed {
    logic [FIELD_W-1:0] max_unlock_ms;
    logic [FIELD_W-1:0] min_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic op;
    logic sense_locked;
    logic [FIELD_W-1:0] timeout_ms;
  } item_t;

  // Input stage contents handed to the control stage
  typedef struct packed {
    logic valid;
    item_t item;
  } stage_t;

  // Saturating increment of a timer
  function automatic logic [TIME_WIDTH-1:0] sat_inc(input logic [TIME_WIDTH-1:0] v);
    return (v == TIME_MAX) ? v : v + TIME_WIDTH'(1);
  endfunction

  // Cut a field value to the timer range
  function automatic logic [TIME_WIDTH-1:0] to_time(input logic [FIELD_W-1:0] t);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(t);
    if (w > WIDE_W'(TIME_MAX)) w = WIDE_W'(TIME_MAX);
    return w[TIME_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/core/luc_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on luc_pkg for field widths.
interface luc_item_if;
  logic valid;
  logic ready;
  logic op;
  logic sense_locked;
  logic [luc_pkg::FIELD_W-1:0] timeout_ms;

  modport source(output valid, output op, output sense_locked, output timeout_ms,
                 input ready);
  modport sink(input valid, input op, input sense_locked, input timeout_ms,
               output ready);
endinterface

interface luc_result_if;
  logic valid;
  logic ready;
  logic drive_on;
  logic [2:0] status;
  logic [luc_pkg::FIELD_W-1:0] drive_duration_ms;
  logic was_clamped;

  modport source(output valid, output drive_on, output status, output drive_duration_ms,
                 output was_clamped, input ready);
  modport sink(input valid, input drive_on, input status, input drive_duration_ms,
               input was_clamped, output ready);
endinterface

FILE: rtl/core/luc_cfg.sv
// Configuration registers of the latch unlock pulse controller.
// Depends on luc_pkg.
module luc_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [luc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [luc_pkg::FIELD_W-1:0] cfg_data,
  output luc_pkg::cfg_t cfg
);

  // Write the addressed register; other indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_unlock_ms <= luc_pkg::MAX_UNLOCK_RESET;
      cfg.min_interval_ms <= luc_pkg::MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        luc_pkg::REG_MAX_UNLOCK: cfg.max_unlock_ms <= cfg_data;
        luc_pkg::REG_MIN_INTERVAL: cfg.min_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/luc_in_reg.sv
// Input register stage: captures one transaction from the item channel.
// Depends on luc_pkg and luc_item_if.
module luc_in_reg (
  input  logic clk,
  input  logic rst,
  luc_item_if.sink item,
  input  logic advance,
  output luc_pkg::stage_t stage
);

  assign item.ready = !stage.valid || advance;

  // Hold the item until the control stage consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (item.ready) begin
      stage.valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      stage.item.op <= item.op;
      stage.item.sense_locked <= item.sense_locked;
      stage.item.timeout_ms <= item.timeout_ms;
    end
  end

endmodule

FILE: rtl/core/luc_ctrl.sv
// Control stage: unlock state, per-item decision logic and result register.
// Depends on luc_pkg and luc_result_if.
module luc_ctrl (
  input  logic clk,
  input  logic rst,
  input  luc_pkg::cfg_t cfg,
  input  luc_pkg::stage_t stage,
  output logic advance,
  luc_result_if.source result
);

  logic driving, driving_next;
  logic ever_unlocked, ever_unlocked_next;
  logic [luc_pkg::TIME_WIDTH-1:0] elapsed_ms, elapsed_ms_next;
  logic [luc_pkg::TIME_WIDTH-1:0] active_timeout_ms, active_timeout_ms_next;
  logic [luc_pkg::TIME_WIDTH-1:0] since_last_ms, since_last_ms_next;

  logic res_drive;
  logic [2:0] res_status;
  logic [luc_pkg::FIELD_W-1:0] res_dur;
  logic res_clamped;

  logic take;
  logic clamped;
  logic too_soon;
  logic [luc_pkg::FIELD_W-1:0] tmo_clamped;
  logic [luc_pkg::TIME_WIDTH-1:0] tmo;
  logic [luc_pkg::TIME_WIDTH-1:0] elapsed_inc;
  logic [luc_pkg::WIDE_W-1:0] dur_wide;

  assign advance = !result.valid || result.ready;
  assign take = stage.valid && advance;

  // Clamp the request and evaluate the interval test
  assign clamped = stage.item.timeout_ms > cfg.max_unlock_ms;
  assign tmo_clamped = clamped ? cfg.max_unlock_ms : stage.item.timeout_ms;
  assign tmo = luc_pkg::to_time(tmo_clamped);
  assign too_soon = ever_unlocked &&
                    (luc_pkg::WIDE_W'(since_last_ms) < luc_pkg::WIDE_W'(cfg.min_interval_ms));
  assign elapsed_inc = luc_pkg::sat_inc(elapsed_ms);
  assign dur_wide = luc_pkg::WIDE_W'(elapsed_inc);

  // Decide next state and result for the item in the input register
  always_comb begin
    driving_next = driving;
    ever_unlocked_next = ever_unlocked;
    elapsed_ms_next = elapsed_ms;
    active_timeout_ms_next = active_timeout_ms;
    since_last_ms_next = since_last_ms;
    res_drive = 1'b0;
    res_status = luc_pkg::ST_NOTHING;
    res_dur = '0;
    res_clamped = 1'b0;
    if (stage.item.op == luc_pkg::OP_TICK) begin
      since_last_ms_next = luc_pkg::sat_inc(since_last_ms);
      if (driving) begin
        elapsed_ms_next = elapsed_inc;
        if (!stage.item.sense_locked) begin
          driving_next = 1'b0;
          res_status = luc_pkg::ST_RELEASED;
          res_dur = dur_wide[luc_pkg::FIELD_W-1:0];
        end else if (elapsed_inc >= active_timeout_ms) begin
          driving_next = 1'b0;
          res_status = luc_pkg::ST_TIMED_OUT;
          res_dur = dur_wide[luc_pkg::FIELD_W-1:0];
        end else begin
          res_drive = 1'b1;
        end
      end
    end else begin
      res_clamped = clamped;
      if (driving) begin
        res_drive = 1'b1;
        res_status = luc_pkg::ST_BUSY;
      end else if (too_soon) begin
        res_status = luc_pkg::ST_TOO_SOON;
      end else if (!stage.item.sense_locked) begin
        res_status = luc_pkg::ST_ALREADY_OPEN;
      end else begin
        ever_unlocked_next = 1'b1;
        since_last_ms_next = '0;
        elapsed_ms_next = '0;
        active_timeout_ms_next = tmo;
        // A zero timeout ends the pulse at once
        if (tmo == '0) begin
          res_status = luc_pkg::ST_TIMED_OUT;
        end else begin
          driving_next = 1'b1;
          res_drive = 1'b1;
          res_status = luc_pkg::ST_STARTED;
        end
      end
    end
  end

  // Update state when the item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      driving <= 1'b0;
      ever_unlocked <= 1'b0;
      elapsed_ms <= '0;
      active_timeout_ms <= '0;
      since_last_ms <= '0;
    end else if (take) begin
      driving <= driving_next;
      ever_unlocked <= ever_unlocked_next;
      elapsed_ms <= elapsed_ms_next;
      active_timeout_ms <= active_timeout_ms_next;
      since_last_ms <= since_last_ms_next;
    end
  end

  // Result register: advance when empty or taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.drive_on <= res_drive;
      result.status <= res_status;
      result.drive_duration_ms <= res_dur;
      result.was_clamped <= res_clamped;
    end
  end

endmodule

FILE: rtl/core/latch_unlock_pulse_controller_unit.sv
// Top level of the latch unlock pulse controller.
// Depends on luc_pkg, luc_if, luc_cfg, luc_in_reg and luc_ctrl.
//
//   channel  | direction | transaction content
//   ---------+-----------+-------------------------------------------------
//   item     | in        | op, sense_locked, timeout_ms
//   result   | out       | drive_on, status, drive_duration_ms, was_clamped
//   cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle sustained while result is not stalled. An accepted item
// loads the input register and its decision then loads the result register,
// which presents it on the port. A stall on result holds both registers;
// item.ready drops only while both are full. Reset (rst, synchronous) clears
// state, valids and loads the configuration defaults.
module latch_unlock_pulse_controller_unit (
  input  logic clk,
  input  logic rst,
  luc_item_if.sink item,
  luc_result_if.source result,
  input  logic cfg_we,
  input  logic [luc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [luc_pkg::FIELD_W-1:0] cfg_data
);

  luc_pkg::cfg_t cfg;
  luc_pkg::stage_t stage;
  logic advance;

  luc_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  luc_in_reg u_in_reg (
    .clk(clk),
    .rst(rst),
    .item(item),
    .advance(advance),
    .stage(stage)
  );

  luc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .stage(stage),
    .advance(advance),
    .result(result)
  );

endmodule

FILE: rtl/core/luc_checker.sv
// Port-level checks on result transactions of the unlock controller.
// Depends on luc_pkg; bound to latch_unlock_pulse_controller_unit below.
module luc_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic drive_on,
  input logic [2:0] status,
  input logic [luc_pkg::FIELD_W-1:0] drive_duration_ms
);

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= luc_pkg::ST_TIMED_OUT)
    else $error("status code out of range");

  // Drive is on only after a start, a busy request or a running tick
  a_drive_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && drive_on) |-> (status == luc_pkg::ST_STARTED ||
                                 status == luc_pkg::ST_BUSY ||
                                 status == luc_pkg::ST_NOTHING))
    else $error("drive on with an ending or rejecting status");

  // Busy means a pulse is running
  a_busy_drive: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == luc_pkg::ST_BUSY) |-> drive_on)
    else $error("busy reported with drive off");

  // Duration is reported only when a pulse ends after ticks
  a_duration: assert property (@(posedge clk) disable iff (rst)
    (res_valid && drive_duration_ms != '0) |->
      (status == luc_pkg::ST_RELEASED || status == luc_pkg::ST_TIMED_OUT))
    else $error("duration reported without a pulse end");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(status) && $stable(drive_on)))
    else $error("stalled result changed");

endmodule

bind latch_unlock_pulse_controller_unit luc_checker u_luc_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .drive_on(result.drive_on),
  .status(result.status),
  .drive_duration_ms(result.drive_duration_ms)
);
